@@ sv/csort_pkg.sv @@
package csort_pkg;

    localparam int unsigned DATA_W        = 16;
    localparam int unsigned ALG_W         = 2;
    localparam int unsigned DEF_MAX_ITEMS = 32;

    // sort method codes
    localparam logic [ALG_W-1:0] ALG_BUBBLE = 2'd0;
    localparam logic [ALG_W-1:0] ALG_SELECT = 2'd1;
    localparam logic [ALG_W-1:0] ALG_INSERT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT,
        ST_B_LOAD,
        ST_B_CMP,
        ST_B_END,
        ST_S_LOAD,
        ST_S_CMP,
        ST_S_SW1,
        ST_S_SW2,
        ST_I_HOLD,
        ST_I_CMP,
        ST_I_PUT,
        ST_O_RUN,
        ST_O_DONE
    } t_state;

    typedef struct packed {
        logic strobe;
        logic last;
        logic trunc;
    } t_res;

endpackage

@@ sv/csort_ram.sv @@
module csort_ram #(
    parameter int unsigned WIDTH = csort_pkg::DATA_W,
    parameter int unsigned DEPTH = csort_pkg::DEF_MAX_ITEMS,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/csort_ctrl.sv @@
module csort_ctrl #(
    parameter int unsigned MAX_ITEMS = csort_pkg::DEF_MAX_ITEMS,
    localparam int unsigned IW       = $clog2(MAX_ITEMS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [csort_pkg::DATA_W-1:0] i_value,
    input  logic                                i_last,
    input  logic [csort_pkg::ALG_W-1:0]         i_alg,
    output logic                                o_we,
    output logic [IW-1:0]                       o_waddr,
    output logic [csort_pkg::DATA_W-1:0]        o_wdata,
    output logic [IW-1:0]                       o_raddr,
    input  logic signed [csort_pkg::DATA_W-1:0] i_rdata,
    output csort_pkg::t_res                     o_res
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] One    = CW'(1);
    localparam logic [CW-1:0] Two    = CW'(2);

    csort_pkg::t_state r_state, n_state;
    csort_pkg::t_res   r_res, n_res;
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_best, n_best;
    logic signed [csort_pkg::DATA_W-1:0] r_hold, n_hold;
    logic signed [csort_pkg::DATA_W-1:0] r_pval, n_pval;

    logic [CW-1:0] cnt_m1, cnt_m2;
    logic [CW-1:0] k_p1, k_p2, k_m1, k_m2, pos_p1, pos_m1;
    logic signed [csort_pkg::DATA_W-1:0] cmp_a, cmp_b;
    logic          gt;

    assign cnt_m1 = r_count - One;
    assign cnt_m2 = r_count - Two;
    assign k_p1   = r_k + One;
    assign k_p2   = r_k + Two;
    assign k_m1   = r_k - One;
    assign k_m2   = r_k - Two;
    assign pos_p1 = r_pos + One;
    assign pos_m1 = r_pos - One;

    // the one shared comparator
    always_comb begin
        if (r_state == csort_pkg::ST_I_CMP) begin
            cmp_a = i_rdata;
            cmp_b = r_hold;
        end else begin
            cmp_a = r_hold;
            cmp_b = i_rdata;
        end
    end
    assign gt = cmp_a > cmp_b;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csort_pkg::ST_IDLE: begin
                if (start && i_last) n_state = csort_pkg::ST_SORT;
            end
            csort_pkg::ST_SORT: begin
                if (r_count < Two) begin
                    n_state = csort_pkg::ST_O_RUN;
                end else begin
                    unique case (i_alg)
                        csort_pkg::ALG_SELECT: n_state = csort_pkg::ST_S_LOAD;
                        csort_pkg::ALG_INSERT: n_state = csort_pkg::ST_I_HOLD;
                        default:               n_state = csort_pkg::ST_B_LOAD;
                    endcase
                end
            end
            csort_pkg::ST_B_LOAD: n_state = csort_pkg::ST_B_CMP;
            csort_pkg::ST_B_CMP: begin
                if (k_p1 == r_pos) n_state = csort_pkg::ST_B_END;
            end
            csort_pkg::ST_B_END: begin
                n_state = (r_pos == One) ? csort_pkg::ST_O_RUN : csort_pkg::ST_B_LOAD;
            end
            csort_pkg::ST_S_LOAD: n_state = csort_pkg::ST_S_CMP;
            csort_pkg::ST_S_CMP: begin
                if (r_k == cnt_m1) n_state = csort_pkg::ST_S_SW1;
            end
            csort_pkg::ST_S_SW1: n_state = csort_pkg::ST_S_SW2;
            csort_pkg::ST_S_SW2: begin
                n_state = (r_pos == cnt_m2) ? csort_pkg::ST_O_RUN : csort_pkg::ST_S_LOAD;
            end
            csort_pkg::ST_I_HOLD: n_state = csort_pkg::ST_I_CMP;
            csort_pkg::ST_I_CMP: begin
                if (gt) begin
                    if (r_k == One) n_state = csort_pkg::ST_I_PUT;
                end else begin
                    n_state = (r_pos == cnt_m1) ? csort_pkg::ST_O_RUN : csort_pkg::ST_I_HOLD;
                end
            end
            csort_pkg::ST_I_PUT: begin
                n_state = (r_pos == cnt_m1) ? csort_pkg::ST_O_RUN : csort_pkg::ST_I_HOLD;
            end
            csort_pkg::ST_O_RUN: begin
                if (r_k == cnt_m1) n_state = csort_pkg::ST_O_DONE;
            end
            csort_pkg::ST_O_DONE: n_state = csort_pkg::ST_IDLE;
            default: n_state = csort_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        busy    = (r_state != csort_pkg::ST_IDLE);
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = r_hold;
        o_raddr = '0;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_k     = r_k;
        n_pos   = r_pos;
        n_best  = r_best;
        n_hold  = r_hold;
        n_pval  = r_pval;
        n_res   = '0;
        unique case (r_state)
            csort_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_count < MaxCnt) begin
                        o_we    = 1'b1;
                        o_waddr = r_count[IW-1:0];
                        o_wdata = i_value;
                        n_count = r_count + One;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            csort_pkg::ST_SORT: begin
                unique case (i_alg)
                    csort_pkg::ALG_SELECT: begin
                        n_pos = '0;
                    end
                    csort_pkg::ALG_INSERT: begin
                        o_raddr = One[IW-1:0];
                        n_pos   = One;
                    end
                    default: begin
                        n_pos = cnt_m1;
                    end
                endcase
            end
            // bubble: carry the running maximum, one compare per cycle
            csort_pkg::ST_B_LOAD: begin
                n_hold  = i_rdata;
                n_k     = '0;
                o_raddr = One[IW-1:0];
            end
            csort_pkg::ST_B_CMP: begin
                o_we    = 1'b1;
                o_waddr = r_k[IW-1:0];
                if (gt) begin
                    o_wdata = i_rdata;
                end else begin
                    o_wdata = r_hold;
                    n_hold  = i_rdata;
                end
                n_k     = k_p1;
                o_raddr = k_p2[IW-1:0];
            end
            csort_pkg::ST_B_END: begin
                o_we    = 1'b1;
                o_waddr = r_pos[IW-1:0];
                o_wdata = r_hold;
                n_pos   = pos_m1;
            end
            // selection: scan for the minimum, then swap in two writes
            csort_pkg::ST_S_LOAD: begin
                n_hold  = i_rdata;
                n_pval  = i_rdata;
                n_best  = r_pos;
                n_k     = pos_p1;
                o_raddr = pos_p1[IW-1:0];
            end
            csort_pkg::ST_S_CMP: begin
                if (gt) begin
                    n_hold = i_rdata;
                    n_best = r_k;
                end
                n_k     = k_p1;
                o_raddr = k_p1[IW-1:0];
            end
            csort_pkg::ST_S_SW1: begin
                o_we    = 1'b1;
                o_waddr = r_best[IW-1:0];
                o_wdata = r_pval;
            end
            csort_pkg::ST_S_SW2: begin
                o_we    = 1'b1;
                o_waddr = r_pos[IW-1:0];
                o_wdata = r_hold;
                n_pos   = pos_p1;
                o_raddr = pos_p1[IW-1:0];
            end
            // insertion: shift larger entries up one at a time
            csort_pkg::ST_I_HOLD: begin
                n_hold  = i_rdata;
                n_k     = r_pos;
                o_raddr = pos_m1[IW-1:0];
            end
            csort_pkg::ST_I_CMP: begin
                o_we    = 1'b1;
                o_waddr = r_k[IW-1:0];
                if (gt) begin
                    o_wdata = i_rdata;
                    n_k     = k_m1;
                    o_raddr = k_m2[IW-1:0];
                end else begin
                    o_wdata = r_hold;
                    n_pos   = pos_p1;
                    o_raddr = pos_p1[IW-1:0];
                end
            end
            csort_pkg::ST_I_PUT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = r_hold;
                n_pos   = pos_p1;
                o_raddr = pos_p1[IW-1:0];
            end
            csort_pkg::ST_O_RUN: begin
                o_raddr      = r_k[IW-1:0];
                n_res.strobe = 1'b1;
                n_res.last   = (r_k == cnt_m1);
                n_res.trunc  = r_ovf;
                n_k          = k_p1;
            end
            csort_pkg::ST_O_DONE: begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (n_state == csort_pkg::ST_O_RUN && r_state != csort_pkg::ST_O_RUN) begin
            n_k = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csort_pkg::ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_res   <= '0;
            r_k     <= '0;
            r_pos   <= '0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_res   <= n_res;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_best  <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_pval <= n_pval;
    end

    assign o_res = r_res;

endmodule

@@ sv/comparison_sort_engine_unit.sv @@
// channel   | direction | signals                                        | request taken when
// ----------+-----------+------------------------------------------------+----------------------
// input     | in        | start, busy, i_value_in, i_last_in             | start & !busy
// result    | out       | o_strobe, o_sorted_value, o_last_out,          | o_strobe (one cycle)
//           |           | o_truncated                                    |
// config    | in        | i_cfg_valid, o_cfg_ready, i_cfg_data           | i_cfg_valid & o_cfg_ready
//
// a request that does not end the batch is stored when taken, unless the batch is full;
// busy stays low. a batch of n values then sorts on one comparator and one ram write
// port, by bubble, selection or insertion sort
// reset is synchronous, active low; it empties the batch and selects bubble sort
// results leave one per cycle and cannot be stalled; busy is high until the last
module comparison_sort_engine_unit #(
    parameter int unsigned MAX_ITEMS = csort_pkg::DEF_MAX_ITEMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input requests
    input  logic                                start,
    output logic                                busy,
    input  logic signed [csort_pkg::DATA_W-1:0] i_value_in,
    input  logic                                i_last_in,
    // results
    output logic                                o_strobe,
    output logic signed [csort_pkg::DATA_W-1:0] o_sorted_value,
    output logic                                o_last_out,
    output logic                                o_truncated,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csort_pkg::ALG_W-1:0]         i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_ITEMS);

    // sort method register, to be written only while idle; the block does not enforce it
    logic [csort_pkg::ALG_W-1:0] r_alg_select;

    // ram side of the sequencer
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [csort_pkg::DATA_W-1:0] ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [csort_pkg::DATA_W-1:0] ram_rdata;
    csort_pkg::t_res              res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg_select <= csort_pkg::ALG_BUBBLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alg_select <= i_cfg_data;
        end
    end

    // value store: one write and one registered read per cycle
    csort_ram #(
        .WIDTH (csort_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // loading, sorting and read-out sequencer around the shared comparator
    csort_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_value (i_value_in),
        .i_last  (i_last_in),
        .i_alg   (r_alg_select),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_res   (res)
    );

    // read data of the store lines up with the registered strobe
    assign o_strobe       = res.strobe;
    assign o_last_out     = res.last;
    assign o_truncated    = res.trunc;
    assign o_sorted_value = ram_rdata;

endmodule

@@ test/comparison_sort_engine_unit_tb.sv @@
`timescale 1ns / 100ps

module comparison_sort_engine_unit_tb;

    localparam int CAPACITY     = csort_pkg::DEF_MAX_ITEMS;
    localparam int SETTLE       = 12;      // cycles for the block to drop back to idle
    localparam int LIMIT_CYCLES = 400000;  // far above the slowest legal run
    localparam int PHASE_QUOTA  = 36;      // at least this many random requests per phase

    // selector value with no method of its own, sorts as bubble
    localparam logic [csort_pkg::ALG_W-1:0] ALG_SPARE = 2'd3;

    typedef struct {
        logic signed [csort_pkg::DATA_W-1:0] val;
        logic                                last;
    } t_req;

    typedef struct {
        logic signed [csort_pkg::DATA_W-1:0] val;
        logic                                last;
        logic                                trunc;
    } t_sorted;

    // dut ports
    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [csort_pkg::DATA_W-1:0] i_value_in = '0;
    logic                                i_last_in = 1'b0;
    logic                                o_strobe;
    logic signed [csort_pkg::DATA_W-1:0] o_sorted_value;
    logic                                o_last_out;
    logic                                o_truncated;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [csort_pkg::ALG_W-1:0]         i_cfg_data = csort_pkg::ALG_BUBBLE;

    // requests waiting to be sent, and sorted values still to come
    t_req    value_feed [$];
    t_sorted sorted_due [$];

    // own copy of the block state
    logic signed [csort_pkg::DATA_W-1:0] batch_vals [CAPACITY];
    int                                  fill = 0;
    bit                                  dropped = 1'b0;
    logic [csort_pkg::ALG_W-1:0]         method_sel = csort_pkg::ALG_BUBBLE;

    // handshake bookkeeping between the edges
    bit req_taken = 1'b0;
    bit feed_hold = 1'b0;
    int gap_pct = 0;

    // run statistics
    int err_count = 0;
    int fed_count = 0;
    int batches_done = 0;
    int overflow_batches = 0;
    int results_seen = 0;
    int cycle_count = 0;

    comparison_sort_engine_unit #(
        .MAX_ITEMS (CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value_in     (i_value_in),
        .i_last_in      (i_last_in),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_truncated    (o_truncated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // sort methods on the local copy of the batch
    // ---------------------------------------------------------------

    function automatic void bubble_sort(int n);
        logic signed [csort_pkg::DATA_W-1:0] t;
        for (int p = 0; p + 1 < n; p++) begin
            for (int k = 0; k + 1 < n - p; k++) begin
                if (batch_vals[k] > batch_vals[k+1]) begin
                    t = batch_vals[k];
                    batch_vals[k] = batch_vals[k+1];
                    batch_vals[k+1] = t;
                end
            end
        end
    endfunction

    function automatic void selection_sort(int n);
        logic signed [csort_pkg::DATA_W-1:0] t;
        int best;
        for (int pos = 0; pos < n; pos++) begin
            best = pos;
            for (int k = pos + 1; k < n; k++) begin
                if (batch_vals[k] < batch_vals[best]) best = k;
            end
            t = batch_vals[pos];
            batch_vals[pos] = batch_vals[best];
            batch_vals[best] = t;
        end
    endfunction

    function automatic void insertion_sort(int n);
        logic signed [csort_pkg::DATA_W-1:0] held;
        int k;
        for (int pos = 1; pos < n; pos++) begin
            held = batch_vals[pos];
            k = pos;
            while (k > 0 && batch_vals[k-1] > held) begin
                batch_vals[k] = batch_vals[k-1];
                k--;
            end
            batch_vals[k] = held;
        end
    endfunction

    // store one accepted request; a batch end queues its sorted values
    function automatic void take_request(logic signed [csort_pkg::DATA_W-1:0] v, logic lst);
        t_sorted r;
        if (fill < CAPACITY) begin
            batch_vals[fill] = v;
            fill++;
        end else begin
            dropped = 1'b1;   // store full, value lost
        end
        if (lst) begin
            case (method_sel)
                csort_pkg::ALG_SELECT: selection_sort(fill);
                csort_pkg::ALG_INSERT: insertion_sort(fill);
                default:               bubble_sort(fill);   // bubble and the spare code
            endcase
            for (int k = 0; k < fill; k++) begin
                r.val   = batch_vals[k];
                r.last  = (k + 1 == fill);
                r.trunc = dropped;
                sorted_due.push_back(r);
            end
            if (dropped) overflow_batches++;
            batches_done++;
            fill    = 0;
            dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // compare one strobed result with the oldest sorted value due
    task automatic check_result();
        t_sorted want;
        results_seen++;
        if (sorted_due.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing due", o_sorted_value));
            return;
        end
        want = sorted_due.pop_front();
        if (o_sorted_value !== want.val)
            report_mismatch($sformatf("sorted_value %0d, want %0d", o_sorted_value, want.val));
        if (o_last_out !== want.last)
            report_mismatch($sformatf("last_out %0b, want %0b", o_last_out, want.last));
        if (o_truncated !== want.trunc)
            report_mismatch($sformatf("truncated %0b, want %0b", o_truncated, want.trunc));
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic void feed(logic signed [csort_pkg::DATA_W-1:0] v, logic lst);
        t_req q;
        q.val  = v;
        q.last = lst;
        value_feed.push_back(q);
        fed_count++;
    endfunction

    // mix of full range, extremes and a narrow band that forces ties
    function automatic logic signed [csort_pkg::DATA_W-1:0] random_value();
        int s;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0:       s = 16'h8000;
                    1:       s = 16'h7fff;
                    2:       s = 16'h0000;
                    3:       s = 16'hffff;
                    default: s = 16'h0001;
                endcase
            end
            1:       s = $urandom_range(0, 8) - 4;
            default: s = $urandom;
        endcase
        return s[csort_pkg::DATA_W-1:0];
    endfunction

    function automatic void feed_batch(int n);
        for (int k = 0; k < n; k++) feed(random_value(), k == n - 1);
    endfunction

    // wait for every sorted value, then let the block settle back to idle
    task automatic drain_and_settle();
        while (value_feed.size() != 0 || sorted_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // one write on the config channel, only while idle
    task automatic write_method(logic [csort_pkg::ALG_W-1:0] code);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= code;
        do @(posedge i_clk); while (!o_cfg_ready);
        method_sel = code;   // takes effect at this edge
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // driver: new request at the falling edge, held until taken
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        feed_hold = start && !req_taken;
        if (req_taken) begin
            void'(value_feed.pop_front());
            req_taken = 1'b0;
        end
        if (!feed_hold) begin
            // random gap between requests, none when gap_pct is 0
            if (value_feed.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                start      <= 1'b1;
                i_value_in <= value_feed[0].val;
                i_last_in  <= value_feed[0].last;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: results and request handshakes seen at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) check_result();
            if (start && !busy) begin
                take_request(i_value_in, i_last_in);
                req_taken = 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d values still due",
                     cycle_count, sorted_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        int                          phase_start;
        int                          len;
        logic [csort_pkg::ALG_W-1:0] code;

        // synchronous reset, held low from the start
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gap_pct = 30;

        // reset method is bubble: short batch with a tie-free mix, then a lone value
        feed(16'sd5, 1'b0);
        feed(-16'sd7, 1'b0);
        feed(16'sd0, 1'b1);
        feed(16'sh8000, 1'b1);
        drain_and_settle();

        // every selector value on the same batch: extremes, sign change, equal pair
        for (int m = 0; m < 4; m++) begin
            case (m)
                0:       code = csort_pkg::ALG_BUBBLE;
                1:       code = csort_pkg::ALG_SELECT;
                2:       code = csort_pkg::ALG_INSERT;
                default: code = ALG_SPARE;
            endcase
            write_method(code);
            feed(16'sh7fff, 1'b0);
            feed(16'sd1, 1'b0);
            feed(16'sh8000, 1'b0);
            feed(-16'sd1, 1'b0);
            feed(16'sh7fff, 1'b1);
            drain_and_settle();
        end

        // random phases: gaps of 30 percent, then 87, then none
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       code = csort_pkg::ALG_SELECT;
                1:       code = csort_pkg::ALG_INSERT;
                2:       code = ALG_SPARE;
                3:       code = csort_pkg::ALG_BUBBLE;
                4:       code = csort_pkg::ALG_INSERT;
                default: code = csort_pkg::ALG_SELECT;
            endcase
            write_method(code);
            gap_pct = (p < 2) ? 30 : (p < 4) ? 87 : 0;
            phase_start = fed_count;
            // every other phase opens with a batch past capacity
            if (p % 2 == 0) feed_batch(CAPACITY + $urandom_range(1, 3));
            while (fed_count - phase_start < PHASE_QUOTA) begin
                case ($urandom_range(0, 9))
                    0:       len = CAPACITY;
                    1:       len = $urandom_range(9, 16);
                    default: len = $urandom_range(1, 8);
                endcase
                feed_batch(len);
            end
            // sender holds off here until all sorted values are back
            drain_and_settle();
        end

        $display("sent %0d requests in %0d batches, %0d of them over capacity",
                 fed_count, batches_done, overflow_batches);
        $display("checked %0d sorted values across all four selector codes", results_seen);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ comparison_sort_engine_unit.f @@
sv/csort_pkg.sv
sv/csort_ram.sv
sv/csort_ctrl.sv
sv/comparison_sort_engine_unit.sv
test/comparison_sort_engine_unit_tb.sv
